>>> rtl/imm_pkg.sv
// imm_pkg: shared types, codes and helpers for the integer matrix multiply block
// no dependencies; imported by the top level and the port checker
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int REQ_W     = 2;
    localparam int IDX_PORT_W = 3;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // request codes, code 3 is unused
    typedef enum logic [REQ_W-1:0] {
        REQ_WR_LEFT  = 2'd0,
        REQ_WR_RIGHT = 2'd1,
        REQ_MULT     = 2'd2
    } t_req;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd3;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // control carried along the read / multiply / accumulate stages
    typedef struct packed {
        logic                  first;
        logic                  last_k;
        logic                  last;
        logic                  mismatch;
        logic                  lvld;
        logic                  rvld;
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
    } t_stage;

    // clamp a dimension register to 1..max_dim
    function automatic logic [CFG_W-1:0] f_eff_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_dim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > max_dim) begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/imm_ram.sv
// imm_ram: generic single-write, single-read memory with registered read data
// no dependencies; used for both matrix stores
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/integer_matrix_multiply.sv
// integer_matrix_multiply: write items load one element per cycle while o_in_ready is high
// and leave it high; it is low while a multiply runs. multiply: a single multiply-accumulate
// walk over every i, j, k (k innermost), then multiply and accumulate stages; a mismatch gives one result
// results go through one output register, the walk stalls while it is full and not taken
// synchronous active-low reset clears control state, sets the dimensions to 8 and marks
// every store entry unwritten (reads as zero) at once, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [imm_pkg::CFG_W-1:0]       i_cfg_data,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [imm_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [imm_pkg::IDX_PORT_W-1:0]  i_row_index,
    input  wire logic [imm_pkg::IDX_PORT_W-1:0]  i_col_index,
    input  wire logic signed [imm_pkg::VAL_W-1:0] i_elem_value,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [imm_pkg::IDX_PORT_W-1:0]  o_out_row,
    output logic      [imm_pkg::IDX_PORT_W-1:0]  o_out_col,
    output logic signed [imm_pkg::VAL_W-1:0]     o_product_value,
    output logic                                 o_last,
    output logic                                 o_size_mismatch
);

    import imm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int SW     = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIM);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // configuration registers
    logic [CFG_W-1:0] r_left_rows, r_left_cols, r_right_rows, r_right_cols;
    logic [CFG_W-1:0] w_lr, w_lc, w_rr, w_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_rows  <= DIM_RESET;
            r_left_cols  <= DIM_RESET;
            r_right_rows <= DIM_RESET;
            r_right_cols <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEFT_ROWS:  r_left_rows  <= i_cfg_data;
                REG_LEFT_COLS:  r_left_cols  <= i_cfg_data;
                REG_RIGHT_ROWS: r_right_rows <= i_cfg_data;
                REG_RIGHT_COLS: r_right_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_lr = f_eff_dim(r_left_rows,  MAX_DIM_C);
    assign w_lc = f_eff_dim(r_left_cols,  MAX_DIM_C);
    assign w_rr = f_eff_dim(r_right_rows, MAX_DIM_C);
    assign w_rc = f_eff_dim(r_right_cols, MAX_DIM_C);

    // request decode
    t_state r_state;
    logic   w_accept, w_wr_left, w_wr_right, w_mult, w_in_range;
    logic [ADDR_W-1:0] w_waddr;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(i_row_index) < MAX_DIM) && (32'(i_col_index) < MAX_DIM);
    assign w_waddr    = ADDR_W'(32'(i_row_index) * MAX_DIM + 32'(i_col_index));

    always_comb begin
        w_wr_left  = 1'b0;
        w_wr_right = 1'b0;
        w_mult     = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_WR_LEFT:  w_wr_left  = w_accept && w_in_range;
            REQ_WR_RIGHT: w_wr_right = w_accept && w_in_range;
            REQ_MULT:     w_mult     = w_accept;
            default: ;
        endcase
    end

    // per-entry written flags, an unwritten entry reads as zero
    logic [DEPTH-1:0] r_left_vld, r_right_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld  <= '0;
            r_right_vld <= '0;
        end else begin
            if (w_wr_left) begin
                r_left_vld[w_waddr] <= 1'b1;
            end
            if (w_wr_right) begin
                r_right_vld[w_waddr] <= 1'b1;
            end
        end
    end

    // walk over i, j, k
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic             r_mm;
    logic             w_adv, w_issue, w_i_last, w_j_last, w_k_last;
    logic [ADDR_W-1:0] w_l_raddr, w_r_raddr;
    t_stage           w_issue_st;

    assign w_adv    = !o_out_valid || i_out_ready;
    assign w_issue  = (r_state == ST_RUN) && w_adv;
    assign w_i_last = (CFG_W'(r_i) == w_lr - 4'd1);
    assign w_j_last = (CFG_W'(r_j) == w_rc - 4'd1);
    assign w_k_last = (CFG_W'(r_k) == w_lc - 4'd1);
    assign w_l_raddr = ADDR_W'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_r_raddr = ADDR_W'(32'(r_k) * MAX_DIM + 32'(r_j));

    always_comb begin
        w_issue_st.first    = r_mm || (r_k == '0);
        w_issue_st.last_k   = r_mm || w_k_last;
        w_issue_st.last     = r_mm || (w_k_last && w_j_last && w_i_last);
        w_issue_st.mismatch = r_mm;
        w_issue_st.lvld     = !r_mm && r_left_vld[w_l_raddr];
        w_issue_st.rvld     = !r_mm && r_right_vld[w_r_raddr];
        w_issue_st.row      = IDX_PORT_W'(r_i);
        w_issue_st.col      = IDX_PORT_W'(r_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_mm    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_mult) begin
                        r_state <= ST_RUN;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_mm    <= (w_lc != w_rr);
                    end
                end
                ST_RUN: begin
                    if (w_issue) begin
                        if (r_mm) begin
                            r_state <= ST_IDLE;
                            r_mm    <= 1'b0;
                        end else if (w_k_last) begin
                            r_k <= '0;
                            if (w_j_last) begin
                                r_j <= '0;
                                if (w_i_last) begin
                                    r_state <= ST_IDLE;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // element stores
    logic [SW-1:0] w_l_rdata, w_r_rdata;

    imm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_left),
        .i_waddr (w_waddr),
        .i_wdata (i_elem_value[SW-1:0]),
        .i_re    (w_issue),
        .i_raddr (w_l_raddr),
        .o_rdata (w_l_rdata)
    );

    imm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_right),
        .i_waddr (w_waddr),
        .i_wdata (i_elem_value[SW-1:0]),
        .i_re    (w_issue),
        .i_raddr (w_r_raddr),
        .o_rdata (w_r_rdata)
    );

    // stage 1: read data present, multiply
    logic   r_s1_valid;
    t_stage r_s1;
    logic signed [SW-1:0] w_l_sx, w_r_sx;
    logic [VAL_W-1:0] w_l32, w_r32, w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= w_issue_st;
        end
    end

    assign w_l_sx = w_l_rdata;
    assign w_r_sx = w_r_rdata;
    assign w_l32  = r_s1.lvld ? VAL_W'(w_l_sx) : '0;
    assign w_r32  = r_s1.rvld ? VAL_W'(w_r_sx) : '0;
    // only the low 32 bits of each product reach the result
    assign w_prod = w_l32 * w_r32;

    // stage 2: registered product, accumulate
    logic             r_s2_valid;
    t_stage           r_s2;
    logic [VAL_W-1:0] r_s2_prod, r_acc, w_acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2      <= r_s1;
            r_s2_prod <= w_prod;
        end
    end

    assign w_acc_sum = r_s2.first ? r_s2_prod : r_acc + r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_acc <= w_acc_sum;
        end
    end

    // output register
    logic w_emit;
    assign w_emit = w_adv && r_s2_valid && r_s2.last_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_out_row       <= r_s2.row;
            o_out_col       <= r_s2.col;
            o_product_value <= w_acc_sum;
            o_last          <= r_s2.last;
            o_size_mismatch <= r_s2.mismatch;
        end
    end

endmodule

`default_nettype wire

>>> rtl/imm_checker.sv
// imm_checker: port-level assertions for integer_matrix_multiply
// depends on imm_pkg; attached to the top level by the bind at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module imm_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             o_in_ready,
    input  wire logic [imm_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic [imm_pkg::IDX_PORT_W-1:0]   o_out_row,
    input  wire logic [imm_pkg::IDX_PORT_W-1:0]   o_out_col,
    input  wire logic signed [imm_pkg::VAL_W-1:0] o_product_value,
    input  wire logic                             o_last,
    input  wire logic                             o_size_mismatch
);

    import imm_pkg::*;

    logic w_in_txn, w_is_write;
    assign w_in_txn   = i_in_valid && o_in_ready;
    assign w_is_write = (i_req_type == REQ_WR_LEFT) || (i_req_type == REQ_WR_RIGHT);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_product_value)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last))
        else $error("result changed while stalled");

    // a mismatch result is a single zero result flagged last
    a_mismatch_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_size_mismatch |-> o_last && o_product_value == '0
            && o_out_row == '0 && o_out_col == '0)
        else $error("malformed size mismatch result");

    // write transactions never stall the request channel
    a_write_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_txn && w_is_write |=> o_in_ready)
        else $error("request channel stalled after a write");

    // a multiply occupies the block, ready drops in the cycle after it is accepted
    a_mult_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_txn && i_req_type == REQ_MULT |=> !o_in_ready)
        else $error("multiply did not occupy the block");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);

`default_nettype wire

>>> test/tb.sv
// tb: self-checking testbench for integer_matrix_multiply, loads both matrices and checks
// every product element against a predictor kept alongside the block
// depends on rtl/imm_pkg.sv and rtl/integer_matrix_multiply.sv
`timescale 1ns / 1ps

module tb;
    import imm_pkg::*;

    localparam int DIM_MAX = 8;
    localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
        logic [VAL_W-1:0]      value;
        logic                  last;
        logic                  mismatch;
    } t_product_elem;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [REQ_W-1:0]       i_req_type = '0;
    logic [IDX_PORT_W-1:0]  i_row_index = '0;
    logic [IDX_PORT_W-1:0]  i_col_index = '0;
    logic [VAL_W-1:0]       i_elem_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [IDX_PORT_W-1:0]  o_out_row;
    logic [IDX_PORT_W-1:0]  o_out_col;
    logic [VAL_W-1:0]       o_product_value;
    logic                   o_last;
    logic                   o_size_mismatch;

    // predictor state
    logic [VAL_W-1:0] left_mat [STORE_DEPTH];
    logic [VAL_W-1:0] right_mat [STORE_DEPTH];
    logic [CFG_W-1:0] dim_reg [4];
    t_product_elem    product_q [$];

    bit no_idle = 1'b0;
    int err_count = 0;
    int n_items = 0;
    int n_mults = 0;
    int n_results = 0;
    int n_mismatch_results = 0;
    int n_cfg_sets = 0;

    integer_matrix_multiply #(
        .MAX_DIM    (8),
        .ELEM_WIDTH (32)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_elem_value    (i_elem_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last),
        .o_size_mismatch (o_size_mismatch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic int clamp_dim(logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > DIM_MAX) begin
            return DIM_MAX;
        end
        return int'(v);
    endfunction

    function automatic logic [VAL_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 40) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // appends one predicted result to the tail of the queue
    function automatic void enqueue_elem(t_product_elem e);
        product_q.insert(product_q.size(), e);
    endfunction

    // updates the stores or queues the product elements for one accepted transaction
    function automatic void apply_req(logic [REQ_W-1:0] req, logic [IDX_PORT_W-1:0] row,
                                      logic [IDX_PORT_W-1:0] col, logic [VAL_W-1:0] val);
        int lr;
        int lc;
        int rr;
        int rc;
        logic [VAL_W-1:0] acc;
        t_product_elem e;
        lr = clamp_dim(dim_reg[REG_LEFT_ROWS]);
        lc = clamp_dim(dim_reg[REG_LEFT_COLS]);
        rr = clamp_dim(dim_reg[REG_RIGHT_ROWS]);
        rc = clamp_dim(dim_reg[REG_RIGHT_COLS]);
        case (req)
            REQ_WR_LEFT: left_mat[row * DIM_MAX + col] = val;
            REQ_WR_RIGHT: right_mat[row * DIM_MAX + col] = val;
            REQ_MULT: begin
                n_mults++;
                if (lc != rr) begin
                    e.row = '0;
                    e.col = '0;
                    e.value = '0;
                    e.last = 1'b1;
                    e.mismatch = 1'b1;
                    enqueue_elem(e);
                end else begin
                    for (int i = 0; i < lr; i++) begin
                        for (int j = 0; j < rc; j++) begin
                            acc = '0;
                            for (int k = 0; k < lc; k++) begin
                                acc = acc + left_mat[i * DIM_MAX + k] * right_mat[k * DIM_MAX + j];
                            end
                            e.row = IDX_PORT_W'(i);
                            e.col = IDX_PORT_W'(j);
                            e.value = acc;
                            e.last = (i == lr - 1) && (j == rc - 1);
                            e.mismatch = 1'b0;
                            enqueue_elem(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [IDX_PORT_W-1:0] row,
                            input logic [IDX_PORT_W-1:0] col, input logic [VAL_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_row_index <= row;
        i_col_index <= col;
        i_elem_value <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        apply_req(req, row, col, val);
        if (req != REQ_UNUSED) begin
            n_items++;
        end
    endtask

    // lowers valid, waits for every expected result, then lets the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dim_reg[idx] = val;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] lc,
                            input logic [CFG_W-1:0] rr, input logic [CFG_W-1:0] rc);
        write_dim(REG_LEFT_ROWS, lr);
        write_dim(REG_LEFT_COLS, lc);
        write_dim(REG_RIGHT_ROWS, rr);
        write_dim(REG_RIGHT_COLS, rc);
        n_cfg_sets++;
    endtask

    task automatic check_result();
        t_product_elem e;
        if (product_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                      o_out_row, o_out_col, o_product_value));
            return;
        end
        e = product_q.pop_front();
        n_results++;
        if (e.mismatch) begin
            n_mismatch_results++;
        end
        if (o_out_row !== e.row) begin
            report_mismatch($sformatf("out_row %0d, expected %0d", o_out_row, e.row));
        end
        if (o_out_col !== e.col) begin
            report_mismatch($sformatf("out_col %0d, expected %0d", o_out_col, e.col));
        end
        if (o_product_value !== e.value) begin
            report_mismatch($sformatf("product_value %h, expected %h at (%0d,%0d)",
                                      o_product_value, e.value, e.row, e.col));
        end
        if (o_last !== e.last) begin
            report_mismatch($sformatf("last %b, expected %b at (%0d,%0d)",
                                      o_last, e.last, e.row, e.col));
        end
        if (o_size_mismatch !== e.mismatch) begin
            report_mismatch($sformatf("size_mismatch %b, expected %b",
                                      o_size_mismatch, e.mismatch));
        end
    endtask

    // result side: random stalls, one check per accepted result
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            check_result();
        end
    end

    // both stores start cleared, so the reset-size product is all zeros
    task automatic test_reset_contents();
        send_req(REQ_MULT, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_extreme_values();
        set_dims(4'd2, 4'd2, 4'd2, 4'd2);
        send_req(REQ_WR_LEFT, 3'd0, 3'd0, 32'h8000_0000);
        send_req(REQ_WR_LEFT, 3'd0, 3'd1, 32'h7fff_ffff);
        send_req(REQ_WR_LEFT, 3'd1, 3'd0, 32'hffff_ffff);
        send_req(REQ_WR_LEFT, 3'd1, 3'd1, 32'h0000_0001);
        send_req(REQ_WR_RIGHT, 3'd0, 3'd0, 32'h8000_0000);
        send_req(REQ_WR_RIGHT, 3'd0, 3'd1, 32'hffff_ffff);
        send_req(REQ_WR_RIGHT, 3'd1, 3'd0, 32'h7fff_ffff);
        send_req(REQ_WR_RIGHT, 3'd1, 3'd1, 32'h7fff_ffff);
        send_req(REQ_MULT, 3'd7, 3'd7, 32'hffff_ffff);
        wait_idle();
    endtask

    task automatic test_size_mismatch();
        set_dims(4'd2, 4'd3, 4'd2, 4'd2);
        send_req(REQ_MULT, '0, '0, '0);
        wait_idle();
        // zero reads as one, still unequal to two
        set_dims(4'd1, 4'd0, 4'd2, 4'd1);
        send_req(REQ_MULT, '0, '0, '0);
        wait_idle();
    endtask

    // out-of-range registers clamp to 1 and 8; elements stored outside the old size now count
    task automatic test_dim_clamping();
        set_dims(4'd0, 4'd15, 4'd9, 4'd0);
        send_req(REQ_WR_LEFT, 3'd0, 3'd7, 32'h7fff_ffff);
        send_req(REQ_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
        send_req(REQ_WR_RIGHT, 3'd7, 3'd0, 32'h8000_0001);
        send_req(REQ_MULT, '0, '0, '0);
        wait_idle();
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(1, 4);
        end
        if (r < 17) begin
            return $urandom_range(5, 7);
        end
        return DIM_MAX;
    endfunction

    // register value that clamps to the wanted size, using 0 and 9..15 now and then
    function automatic logic [CFG_W-1:0] raw_dim(int eff);
        if (eff == 1 && $urandom_range(0, 2) == 0) begin
            return 4'd0;
        end
        if (eff == DIM_MAX && $urandom_range(0, 2) == 0) begin
            return CFG_W'($urandom_range(9, 15));
        end
        return CFG_W'(eff);
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                send_req(REQ_UNUSED, 3'($urandom), 3'($urandom), $urandom);
            end else begin
                send_req(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), rand_elem());
            end
        end
    endtask

    task automatic test_random_phases();
        int lr;
        int lc;
        int rr;
        int rc;
        int start;
        start = n_items;
        while (n_items - start < RANDOM_ITEMS) begin
            wait_idle();
            lr = pick_dim();
            lc = pick_dim();
            rr = ($urandom_range(0, 6) == 0) ? pick_dim() : lc;
            rc = pick_dim();
            set_dims(raw_dim(lr), raw_dim(lc), raw_dim(rr), raw_dim(rc));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < lr; i++) begin
                for (int j = 0; j < lc; j++) begin
                    maybe_noise();
                    send_req(REQ_WR_LEFT, 3'(i), 3'(j), rand_elem());
                end
            end
            for (int i = 0; i < rr; i++) begin
                for (int j = 0; j < rc; j++) begin
                    maybe_noise();
                    send_req(REQ_WR_RIGHT, 3'(i), 3'(j), rand_elem());
                end
            end
            send_req(REQ_MULT, 3'($urandom), 3'($urandom), $urandom);
            if ($urandom_range(0, 3) == 0) begin
                // back to back multiply on unchanged stores
                send_req(REQ_MULT, 3'($urandom), 3'($urandom), $urandom);
            end
            if ($urandom_range(0, 2) == 0) begin
                // patch a few elements right behind the multiply, then multiply again
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_req(REQ_WR_LEFT, 3'($urandom_range(0, lr - 1)),
                                 3'($urandom_range(0, lc - 1)), rand_elem());
                    end else begin
                        send_req(REQ_WR_RIGHT, 3'($urandom_range(0, rr - 1)),
                                 3'($urandom_range(0, rc - 1)), rand_elem());
                    end
                end
                send_req(REQ_MULT, 3'($urandom), 3'($urandom), $urandom);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            left_mat[i] = '0;
            right_mat[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            dim_reg[i] = DIM_RESET;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_extreme_values();
        test_size_mismatch();
        test_dim_clamping();
        test_random_phases();
        wait_idle();

        $display("summary: %0d load/multiply transactions, %0d multiplies, %0d results checked",
                 n_items, n_mults, n_results);
        $display("summary: %0d size mismatch results over %0d dimension settings",
                 n_mismatch_results, n_cfg_sets);
        if (err_count == 0 && product_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", product_q.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
